### hdl/apr_pkg.sv
// Shared types, constants and state encoding for the aging page replacement block.
package apr_pkg;

  localparam int MAX_FRAMES_DEF = 16;
  localparam int PAGE_BITS_DEF  = 16;

  localparam int PAGE_W  = 16;
  localparam int CFG_W   = 5;
  localparam int FRAME_W = 4;
  localparam int MISS_W  = 32;
  localparam int AGE_W   = 8;

  localparam logic [AGE_W-1:0] AGE_TOP = 8'h80;
  localparam logic [MISS_W-1:0] MISS_MAX = '1;

  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
  } page_item_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame_index;
    logic               evicted;
    logic [PAGE_W-1:0]  evicted_page;
    logic [MISS_W-1:0]  miss_total;
  } result_t;

  typedef struct packed {
    logic rd_en;
    logic age_we;
    logic page_we;
  } store_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

endpackage

### hdl/apr_stream_if.sv
// Valid/ready channel carrying one item of a given payload type.
interface apr_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/apr_frame_store.sv
// Per-frame storage: page tag memory, age memory and valid flags.
module apr_frame_store
  import apr_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int IW         = 4,
  parameter int PW         = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  store_ctl_t       ctl_i,
  input  logic [IW-1:0]    rd_addr_i,
  input  logic [IW-1:0]    wr_addr_i,
  input  logic [AGE_W-1:0] age_wdata_i,
  input  logic [PW-1:0]    page_wdata_i,
  output logic [PW-1:0]    rd_page_o,
  output logic [AGE_W-1:0] rd_age_o,
  output logic             rd_valid_o
);

  logic [PW-1:0]    page_mem [MAX_FRAMES];
  logic [AGE_W-1:0] age_mem  [MAX_FRAMES];

  logic [MAX_FRAMES-1:0] valid_q;
  logic [MAX_FRAMES-1:0] age_ok_q;
  logic                  rd_valid_q;
  logic                  rd_ok_q;
  logic [AGE_W-1:0]      rd_age_q;
  logic [PW-1:0]         rd_page_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      age_ok_q   <= '0;
      rd_valid_q <= 1'b0;
      rd_ok_q    <= 1'b0;
    end else begin
      if (ctl_i.page_we) valid_q[wr_addr_i] <= 1'b1;
      if (ctl_i.age_we) age_ok_q[wr_addr_i] <= 1'b1;
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
        rd_ok_q    <= age_ok_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.page_we) page_mem[wr_addr_i] <= page_wdata_i;
    if (ctl_i.age_we) age_mem[wr_addr_i] <= age_wdata_i;
    if (ctl_i.rd_en) begin
      rd_page_q <= page_mem[rd_addr_i];
      rd_age_q  <= age_mem[rd_addr_i];
    end
  end

  // an age entry never written reads as zero
  assign rd_age_o   = rd_ok_q ? rd_age_q : '0;
  assign rd_page_o  = rd_page_q;
  assign rd_valid_o = rd_valid_q;

endmodule

### hdl/apr_ctrl.sv
// Scan sequencer: one frame compared per cycle, then the chosen frame is updated.
module apr_ctrl
  import apr_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int IW         = 4,
  parameter int NW         = 5,
  parameter int PW         = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [NW-1:0]    n_active_i,
  input  logic             in_valid_i,
  input  logic [PW-1:0]    in_page_i,
  output logic             in_ready_o,
  input  logic             res_ok_i,
  output logic             res_load_o,
  output result_t          res_o,
  output store_ctl_t       ctl_o,
  output logic [IW-1:0]    rd_addr_o,
  output logic [IW-1:0]    wr_addr_o,
  output logic [AGE_W-1:0] age_wdata_o,
  output logic [PW-1:0]    page_wdata_o,
  input  logic [PW-1:0]    rd_page_i,
  input  logic [AGE_W-1:0] rd_age_i,
  input  logic             rd_valid_i
);

  state_e state_q, state_d;
  logic [IW-1:0]     cnt_q, cnt_d;
  logic [PW-1:0]     page_q, page_d;
  logic              have_hit_q, have_hit_d, have_free_q, have_free_d;
  logic [IW-1:0]     hit_at_q, hit_at_d, free_at_q, free_at_d, min_at_q, min_at_d;
  logic [AGE_W-1:0]  hit_age_q, hit_age_d, free_age_q, free_age_d, min_age_q, min_age_d;
  logic [PW-1:0]     min_page_q, min_page_d;
  logic [MISS_W-1:0] miss_q, miss_d;

  logic              last;
  logic [IW-1:0]     chosen;
  logic [AGE_W-1:0]  chosen_age;
  logic [MISS_W-1:0] miss_next;
  logic              evict;

  assign last  = (NW'(cnt_q) + NW'(1)) == n_active_i;
  assign evict = !have_hit_q && !have_free_q;

  always_comb begin
    priority if (have_hit_q) begin
      chosen     = hit_at_q;
      chosen_age = hit_age_q;
    end else if (have_free_q) begin
      chosen     = free_at_q;
      chosen_age = free_age_q;
    end else begin
      chosen     = min_at_q;
      chosen_age = min_age_q;
    end
  end

  assign miss_next = (have_hit_q || miss_q == MISS_MAX) ? miss_q : miss_q + MISS_W'(1);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    page_d       = page_q;
    have_hit_d   = have_hit_q;
    have_free_d  = have_free_q;
    hit_at_d     = hit_at_q;
    hit_age_d    = hit_age_q;
    free_at_d    = free_at_q;
    free_age_d   = free_age_q;
    min_at_d     = min_at_q;
    min_age_d    = min_age_q;
    min_page_d   = min_page_q;
    miss_d       = miss_q;
    in_ready_o   = 1'b0;
    res_load_o   = 1'b0;
    ctl_o        = '0;
    rd_addr_o    = '0;
    wr_addr_o    = cnt_q;
    age_wdata_o  = rd_age_i >> 1;
    page_wdata_o = page_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctl_o.rd_en = in_valid_i;
        if (in_valid_i) begin
          page_d      = in_page_i;
          cnt_d       = '0;
          have_hit_d  = 1'b0;
          have_free_d = 1'b0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // every active frame ages now; the chosen one gets its top bit at the end
        ctl_o.age_we = 1'b1;
        ctl_o.rd_en  = !last;
        rd_addr_o    = cnt_q + IW'(1);
        if (!have_hit_q && rd_valid_i && rd_page_i == page_q) begin
          have_hit_d = 1'b1;
          hit_at_d   = cnt_q;
          hit_age_d  = rd_age_i;
        end
        if (!have_free_q && !rd_valid_i) begin
          have_free_d = 1'b1;
          free_at_d   = cnt_q;
          free_age_d  = rd_age_i;
        end
        if (cnt_q == '0 || rd_age_i < min_age_q) begin
          min_at_d   = cnt_q;
          min_age_d  = rd_age_i;
          min_page_d = rd_page_i;
        end
        if (last) state_d = ST_FIN;
        else cnt_d = cnt_q + IW'(1);
      end
      ST_FIN: begin
        wr_addr_o   = chosen;
        age_wdata_o = (chosen_age >> 1) | AGE_TOP;
        if (res_ok_i) begin
          res_load_o    = 1'b1;
          ctl_o.age_we  = 1'b1;
          ctl_o.page_we = !have_hit_q;
          miss_d        = miss_next;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_o.hit          = have_hit_q;
    res_o.frame_index  = FRAME_W'(chosen);
    res_o.evicted      = evict;
    res_o.evicted_page = evict ? PAGE_W'(min_page_q) : '0;
    res_o.miss_total   = miss_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      have_hit_q  <= 1'b0;
      have_free_q <= 1'b0;
      miss_q      <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      have_hit_q  <= have_hit_d;
      have_free_q <= have_free_d;
      miss_q      <= miss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q     <= page_d;
    hit_at_q   <= hit_at_d;
    hit_age_q  <= hit_age_d;
    free_at_q  <= free_at_d;
    free_age_q <= free_age_d;
    min_at_q   <= min_at_d;
    min_age_q  <= min_age_d;
    min_page_q <= min_page_d;
  end

`ifndef NO_ASSERTIONS
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> NW'(cnt_q) < n_active_i)
    else $error("scan index beyond active frames");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && have_hit_q) |-> NW'(hit_at_q) < n_active_i)
    else $error("hit frame beyond active frames");

  a_miss_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> miss_q >= $past(miss_q))
    else $error("miss count went down");

  a_fin_one_cycle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && last) |=> state_q == ST_FIN)
    else $error("scan did not end after last frame");
`endif

endmodule

### hdl/aging_page_replacement_core.sv
// Aging page replacement: frames_in_use n active frames scanned one per cycle.
// Flow: an accepted item is scanned over the active frames, then the finish
// state loads the result register once it is free; a new item is taken only
// after that; one compare unit walks the frame memories one entry per cycle.
// Reset: valid and age flags clear at once; no clearing pass; page tags undefined.
// Frame count register resets to MAX_FRAMES; miss count resets to zero.
module aging_page_replacement_core
  import apr_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  apr_stream_if.sink       in_i,
  apr_stream_if.source     out_o
);

  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NW = $clog2(MAX_FRAMES + 1);
  localparam int PW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

  logic [NW-1:0] n_active_q;
  logic          out_valid_q;
  result_t       out_data_q;

  store_ctl_t       ctl;
  logic [IW-1:0]    rd_addr, wr_addr;
  logic [AGE_W-1:0] age_wdata, rd_age;
  logic [PW-1:0]    page_wdata, rd_page, in_page;
  logic             rd_valid;
  logic             res_ok, res_load;
  result_t          res;

  page_item_t in_item;
  assign in_item = in_i.data;
  assign in_page = in_item.page_number[PW-1:0];

  // clamp the written count into 1..MAX_FRAMES
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_active_q <= NW'(MAX_FRAMES);
    end else if (cfg_we_i) begin
      if (cfg_wdata_i == '0) n_active_q <= NW'(1);
      else if (int'(cfg_wdata_i) > MAX_FRAMES) n_active_q <= NW'(MAX_FRAMES);
      else n_active_q <= NW'(cfg_wdata_i);
    end
  end

  assign res_ok = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) out_data_q <= res;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  apr_ctrl #(
    .MAX_FRAMES (MAX_FRAMES),
    .IW         (IW),
    .NW         (NW),
    .PW         (PW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .n_active_i   (n_active_q),
    .in_valid_i   (in_i.valid),
    .in_page_i    (in_page),
    .in_ready_o   (in_i.ready),
    .res_ok_i     (res_ok),
    .res_load_o   (res_load),
    .res_o        (res),
    .ctl_o        (ctl),
    .rd_addr_o    (rd_addr),
    .wr_addr_o    (wr_addr),
    .age_wdata_o  (age_wdata),
    .page_wdata_o (page_wdata),
    .rd_page_i    (rd_page),
    .rd_age_i     (rd_age),
    .rd_valid_i   (rd_valid)
  );

  apr_frame_store #(
    .MAX_FRAMES (MAX_FRAMES),
    .IW         (IW),
    .PW         (PW)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .rd_addr_i    (rd_addr),
    .wr_addr_i    (wr_addr),
    .age_wdata_i  (age_wdata),
    .page_wdata_i (page_wdata),
    .rd_page_o    (rd_page),
    .rd_age_o     (rd_age),
    .rd_valid_o   (rd_valid)
  );

`ifndef NO_ASSERTIONS
  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_q || out_o.ready))
    else $error("result register overwritten before it was taken");

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second item accepted during a scan");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_active_q != '0 && int'(n_active_q) <= MAX_FRAMES)
    else $error("active frame count out of range");
`endif

endmodule

### tb/aging_page_replacement_core_tb.sv
// Self-checking testbench for the aging page replacement core.
module aging_page_replacement_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import apr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 40;
  localparam int POOL_SIZE      = 24;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  apr_stream_if #(.T(page_item_t)) page_if ();
  apr_stream_if #(.T(result_t))    res_if ();

  aging_page_replacement_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (page_if),
    .out_o       (res_if)
  );

  // Shadow copy of the frame table
  logic [PAGE_W-1:0] shadow_page  [MAX_FRAMES_DEF];
  logic              shadow_valid [MAX_FRAMES_DEF];
  logic [AGE_W-1:0]  shadow_age   [MAX_FRAMES_DEF];
  logic [MISS_W-1:0] shadow_misses;
  logic [CFG_W-1:0]  shadow_frames;

  result_t pending_results[$];
  int      err_cnt;
  bit      src_idle_on;
  bit      snk_idle_on;
  bit      long_hold_req;
  logic [PAGE_W-1:0] page_pool [POOL_SIZE];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic result_t predict_frame(input logic [PAGE_W-1:0] page);
    int      n;
    int      hit_at;
    int      free_at;
    int      old_at;
    int      min_age;
    int      chosen;
    bit      have_hit;
    bit      have_free;
    result_t r;
    n = int'(shadow_frames);
    if (n < 1) n = 1;
    if (n > MAX_FRAMES_DEF) n = MAX_FRAMES_DEF;
    hit_at = 0;
    free_at = 0;
    old_at = 0;
    min_age = 256;
    have_hit = 1'b0;
    have_free = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (shadow_valid[i] && shadow_page[i] == page && !have_hit) begin
        have_hit = 1'b1;
        hit_at = i;
      end
      if (!shadow_valid[i] && !have_free) begin
        have_free = 1'b1;
        free_at = i;
      end
      if (int'(shadow_age[i]) < min_age) begin
        min_age = int'(shadow_age[i]);
        old_at = i;
      end
    end
    r = '0;
    if (have_hit) begin
      chosen = hit_at;
      r.hit = 1'b1;
    end else begin
      if (have_free) begin
        chosen = free_at;
      end else begin
        chosen = old_at;
        r.evicted = 1'b1;
        r.evicted_page = shadow_page[chosen];
      end
      shadow_valid[chosen] = 1'b1;
      shadow_page[chosen] = page;
      if (shadow_misses != MISS_MAX) shadow_misses = shadow_misses + MISS_W'(1);
    end
    // filled frames age from their old value, not from zero
    for (int i = 0; i < n; i++) begin
      if (i == chosen) shadow_age[i] = (shadow_age[i] >> 1) | AGE_TOP;
      else shadow_age[i] = shadow_age[i] >> 1;
    end
    r.frame_index = chosen[FRAME_W-1:0];
    r.miss_total = shadow_misses;
    return r;
  endfunction

  task automatic send_page(input logic [PAGE_W-1:0] page);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      page_if.valid = 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk_i);
    end
    @(negedge clk_i);
    page_if.valid = 1'b1;
    page_if.data = '{page_number: page};
    @(posedge clk_i);
    while (!page_if.ready) @(posedge clk_i);
    pending_results.push_back(predict_frame(page));
  endtask

  task automatic quiet_and_drain();
    @(negedge clk_i);
    page_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_frames(input logic [CFG_W-1:0] value);
    quiet_and_drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    shadow_frames = value;
  endtask

  task automatic refill_pool();
    for (int k = 0; k < POOL_SIZE; k++) page_pool[k] = PAGE_W'($urandom_range(0, 65535));
  endtask

  // Mostly a working set a little larger than the frame count, so hits,
  // fills and evictions all show up; the rest is random pages.
  function automatic logic [PAGE_W-1:0] pick_page();
    int n;
    int sel;
    n = int'(shadow_frames);
    if (n < 1) n = 1;
    if (n > MAX_FRAMES_DEF) n = MAX_FRAMES_DEF;
    sel = $urandom_range(0, 9);
    if (sel < 7) return page_pool[$urandom_range(0, n + 3)];
    if (sel < 8) return page_pool[$urandom_range(0, POOL_SIZE - 1)];
    return PAGE_W'($urandom_range(0, 65535));
  endfunction

  task automatic test_directed();
    // reset frame count, extreme pages, a hit
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'h5555);
    send_page(16'hAAAA);
    // two frames: evictions by age
    set_frames(5'd2);
    send_page(16'h1234);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h1234);
    // back to full size: frames above two kept their pages
    set_frames(5'd16);
    send_page(16'h5555);
    send_page(16'hAAAA);
    // zero frames acts as one
    set_frames(5'd0);
    send_page(16'h0001);
    send_page(16'h0002);
    send_page(16'h0002);
    // one frame
    set_frames(5'd1);
    send_page(16'h8000);
    send_page(16'h0002);
    // above the built count saturates
    set_frames(5'd31);
    send_page(16'h7FFF);
    send_page(16'h5555);
  endtask

  task automatic test_random_settings();
    logic [CFG_W-1:0] settings [12];
    settings = '{5'd16, 5'd1, 5'd8, 5'd0, 5'd31, 5'd4, 5'd16, 5'd2, 5'd12, 5'd17, 5'd7,
                 5'd16};
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    foreach (settings[p]) begin
      set_frames(settings[p]);
      refill_pool();
      repeat (125) send_page(pick_page());
    end
  endtask

  task automatic test_backpressure();
    set_frames(5'd16);
    refill_pool();
    long_hold_req = 1'b1;
    repeat (20) send_page(pick_page());
    // sender pauses until everything is back
    quiet_and_drain();
    repeat (10) send_page(pick_page());
  endtask

  task automatic test_full_rate();
    set_frames(5'd5);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    refill_pool();
    repeat (120) send_page(pick_page());
    set_frames(5'd16);
    refill_pool();
    repeat (120) send_page(pick_page());
  endtask

  // result sink: random stall bursts, one long hold on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 7) == 0) begin
        res_if.ready = 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk_i);
      end else begin
        res_if.ready = rst_ni;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result item: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit || got.frame_index !== want.frame_index ||
            got.evicted !== want.evicted || got.evicted_page !== want.evicted_page ||
            got.miss_total !== want.miss_total) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display({"mismatch: hit %0b/%0b frame %0d/%0d evicted %0b/%0b",
                      " page %h/%h misses %0d/%0d"},
                     want.hit, got.hit, want.frame_index, got.frame_index,
                     want.evicted, got.evicted, want.evicted_page, got.evicted_page,
                     want.miss_total, got.miss_total);
          end
        end
      end
    end
  end

  // watchdog: cycles without any accepted item on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((page_if.valid && page_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    page_if.valid = 1'b0;
    page_if.data = '0;
    err_cnt = 0;
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    long_hold_req = 1'b0;
    for (int i = 0; i < MAX_FRAMES_DEF; i++) begin
      shadow_page[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_age[i] = '0;
    end
    shadow_misses = '0;
    shadow_frames = CFG_W'(MAX_FRAMES_DEF);
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_settings();
    test_backpressure();
    test_full_rate();

    quiet_and_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### aging_page_replacement_core.f
hdl/apr_pkg.sv
hdl/apr_stream_if.sv
hdl/apr_frame_store.sv
hdl/apr_ctrl.sv
hdl/aging_page_replacement_core.sv
tb/aging_page_replacement_core_tb.sv
